FILE: sv/m4v_pkg.sv
// ----------------------------------------------------------------------------
// m4v_pkg
// Types and constants shared by the 4x4 matrix by vector transform block.
// ----------------------------------------------------------------------------
package m4v_pkg;

   localparam int WORD_W  = 32;
   localparam int VEC_LEN = 4;
   localparam int IDX_W   = 2;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [0:0] {
      CMD_LOAD  = 1'b0,
      CMD_XFORM = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type              command;
      logic [IDX_W-1:0]     column_index;
      logic [IDX_W-1:0]     row_index;
      logic signed [WORD_W-1:0] element_value;
   } item_ctl_type;

endpackage

FILE: sv/mat4_vec4_transform.sv
// ----------------------------------------------------------------------------
// mat4_vec4_transform
// Throughput: one item per cycle, loads and transforms alike, while rsp_ready
// does not hold back a result. Four column cells of two stages each (multiply,
// then add) plus an output register form the pipeline. Reset sets the matrix
// to identity and empties the pipeline.
// ----------------------------------------------------------------------------
module mat4_vec4_transform
   import m4v_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [1:0]  req_column_index,
   input  logic [1:0]  req_row_index,
   input  logic signed [31:0] req_element_value,
   input  logic signed [31:0] req_in_x,
   input  logic signed [31:0] req_in_y,
   input  logic signed [31:0] req_in_z,
   input  logic signed [31:0] req_in_w,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic signed [31:0] rsp_out_w,
   output logic        rsp_overflow
);

   localparam int ACC_W = 2 * WORD_W + 2 - FRAC_BITS;

   logic                    chain_valid [VEC_LEN+1];
   logic                    chain_ready [VEC_LEN+1];
   item_ctl_type            chain_ctl   [VEC_LEN+1];
   word_type                chain_vec   [VEC_LEN+1][VEC_LEN];
   logic signed [ACC_W-1:0] chain_sum   [VEC_LEN+1][VEC_LEN];
   word_type                rsp_word    [VEC_LEN];

   assign chain_valid[0]          = req_valid;
   assign req_ready               = chain_ready[0];
   assign chain_ctl[0].command    = cmd_type'(req_command);
   assign chain_ctl[0].column_index  = req_column_index;
   assign chain_ctl[0].row_index     = req_row_index;
   assign chain_ctl[0].element_value = req_element_value;
   assign chain_vec[0][0] = req_in_x;
   assign chain_vec[0][1] = req_in_y;
   assign chain_vec[0][2] = req_in_z;
   assign chain_vec[0][3] = req_in_w;

   always_comb begin
      for (int r = 0; r < VEC_LEN; r++) begin
         chain_sum[0][r] = '0;
      end
   end

   for (genvar c = 0; c < VEC_LEN; c++) begin : g_cell
      m4v_cell #(
         .FRAC_BITS (FRAC_BITS),
         .COL_INDEX (c)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[c]),
         .in_ready  (chain_ready[c]),
         .in_ctl    (chain_ctl[c]),
         .in_vec    (chain_vec[c]),
         .in_sum    (chain_sum[c]),
         .out_valid (chain_valid[c+1]),
         .out_ready (chain_ready[c+1]),
         .out_ctl   (chain_ctl[c+1]),
         .out_vec   (chain_vec[c+1]),
         .out_sum   (chain_sum[c+1])
      );
   end

   m4v_out_stage #(
      .FRAC_BITS (FRAC_BITS)
   ) u_out (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (chain_valid[VEC_LEN]),
      .in_ready     (chain_ready[VEC_LEN]),
      .in_ctl       (chain_ctl[VEC_LEN]),
      .in_sum       (chain_sum[VEC_LEN]),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word     (rsp_word),
      .rsp_overflow (rsp_overflow)
   );

   assign rsp_out_x = rsp_word[0];
   assign rsp_out_y = rsp_word[1];
   assign rsp_out_z = rsp_word[2];
   assign rsp_out_w = rsp_word[3];

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

   a_no_stall_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Request stalled while the output register is empty.");

   a_overflow_saturates : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |->
         (rsp_out_x == 32'sh7fffffff || rsp_out_x == 32'sh80000000 ||
          rsp_out_y == 32'sh7fffffff || rsp_out_y == 32'sh80000000 ||
          rsp_out_z == 32'sh7fffffff || rsp_out_z == 32'sh80000000 ||
          rsp_out_w == 32'sh7fffffff || rsp_out_w == 32'sh80000000))
      else $error("Overflow flagged without a saturated component.");

endmodule

FILE: sv/m4v_cell.sv
// ----------------------------------------------------------------------------
// m4v_cell
// One column cell: holds one matrix column, scales it by the matching vector
// component and adds the result to the partial sums from the previous cell.
// ----------------------------------------------------------------------------
module m4v_cell
   import m4v_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int COL_INDEX = 0,
   localparam int ACC_W    = 2 * WORD_W + 2 - FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  item_ctl_type            in_ctl,
   input  word_type                in_vec [VEC_LEN],
   input  logic signed [ACC_W-1:0] in_sum [VEC_LEN],
   output logic                    out_valid,
   input  logic                    out_ready,
   output item_ctl_type            out_ctl,
   output word_type                out_vec [VEC_LEN],
   output logic signed [ACC_W-1:0] out_sum [VEC_LEN]
);

   localparam int PROD_W = 2 * WORD_W;
   localparam word_type UNITY = word_type'(1) << FRAC_BITS;

   word_type                    col_ff [VEC_LEN];
   logic                        va_ff;
   item_ctl_type                ctl_a_ff;
   word_type                    vec_a_ff [VEC_LEN];
   logic signed [ACC_W-1:0]     sum_a_ff [VEC_LEN];
   logic signed [PROD_W-1:0]    prod_ff [VEC_LEN];
   logic signed [PROD_W-1:0]    prod_in [VEC_LEN];
   logic                        vb_ff;
   item_ctl_type                ctl_b_ff;
   word_type                    vec_b_ff [VEC_LEN];
   logic signed [ACC_W-1:0]     sum_b_ff [VEC_LEN];
   logic signed [ACC_W-1:0]     sum_b_in [VEC_LEN];
   logic                        a_take;
   logic                        b_take;
   logic                        load_hit;

   assign b_take   = !vb_ff || out_ready;
   assign a_take   = !va_ff || b_take;
   assign in_ready = a_take;
   assign load_hit = a_take && in_valid && (in_ctl.command == CMD_LOAD)
                     && (in_ctl.column_index == IDX_W'(COL_INDEX));

   always_comb begin
      for (int r = 0; r < VEC_LEN; r++) begin
         prod_in[r]  = PROD_W'(col_ff[r]) * PROD_W'(in_vec[COL_INDEX]);
         sum_b_in[r] = sum_a_ff[r] + ACC_W'(prod_ff[r] >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < VEC_LEN; r++) begin
            col_ff[r] <= (r == COL_INDEX) ? UNITY : '0;
         end
      end else if (load_hit) begin
         col_ff[in_ctl.row_index] <= in_ctl.element_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (a_take) begin
            va_ff <= in_valid;
         end
         if (b_take) begin
            vb_ff <= va_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_take) begin
         ctl_a_ff <= in_ctl;
         for (int r = 0; r < VEC_LEN; r++) begin
            vec_a_ff[r] <= in_vec[r];
            sum_a_ff[r] <= in_sum[r];
            prod_ff[r]  <= prod_in[r];
         end
      end
      if (b_take) begin
         ctl_b_ff <= ctl_a_ff;
         for (int r = 0; r < VEC_LEN; r++) begin
            vec_b_ff[r] <= vec_a_ff[r];
            sum_b_ff[r] <= sum_b_in[r];
         end
      end
   end

   assign out_valid = vb_ff;
   assign out_ctl   = ctl_b_ff;
   assign out_vec   = vec_b_ff;
   assign out_sum   = sum_b_ff;

endmodule

FILE: sv/m4v_out_stage.sv
// ----------------------------------------------------------------------------
// m4v_out_stage
// Saturates the four sums to 32 bits and holds the result until its transfer.
// Load items end here without a result.
// ----------------------------------------------------------------------------
module m4v_out_stage
   import m4v_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   localparam int ACC_W    = 2 * WORD_W + 2 - FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  item_ctl_type            in_ctl,
   input  logic signed [ACC_W-1:0] in_sum [VEC_LEN],
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output word_type                rsp_word [VEC_LEN],
   output logic                    rsp_overflow
);

   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   logic                 rsp_valid_ff;
   word_type             word_ff [VEC_LEN];
   word_type             word_in [VEC_LEN];
   logic                 ovf_ff;
   logic                 ovf_in;
   logic [VEC_LEN-1:0]   clip;
   logic                 take;
   logic                 is_xform;

   assign take     = !rsp_valid_ff || rsp_ready;
   assign is_xform = (in_ctl.command == CMD_XFORM);
   assign in_ready = take || !is_xform;

   always_comb begin
      for (int r = 0; r < VEC_LEN; r++) begin
         clip[r] = !((&in_sum[r][ACC_W-1:WORD_W-1]) || !(|in_sum[r][ACC_W-1:WORD_W-1]));
         if (clip[r]) begin
            word_in[r] = in_sum[r][ACC_W-1] ? WORD_MIN : WORD_MAX;
         end else begin
            word_in[r] = in_sum[r][WORD_W-1:0];
         end
      end
      ovf_in = |clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= in_valid && is_xform;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid && is_xform) begin
         word_ff <= word_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word     = word_ff;
   assign rsp_overflow = ovf_ff;

endmodule
